// ===== rtl/csvfs_pkg.sv =====
`default_nettype none

package csvfs_pkg;

    // Default sizing
    localparam int DEF_MAX_FIELD_COUNT = 32;
    localparam int DEF_FIELD_BYTES     = 64;

    // Special bytes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Scanner states, one-hot
    typedef enum logic [3:0] {
        ST_START  = 4'b0001,
        ST_PLAIN  = 4'b0010,
        ST_QUOTED = 4'b0100,
        ST_AFTERQ = 4'b1000
    } t_scan_state;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } t_item;

    // One result word
    typedef struct packed {
        logic       write_valid;
        logic [4:0] field_index;
        logic [5:0] char_pos;
        logic [7:0] char_byte;
        logic       field_opened;
        logic [5:0] field_size;
        logic       record_done;
        logic [5:0] field_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/csvfs_if.sv =====
`default_nettype none

// Input channel: one record byte or an end-of-record marker per word
interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_record;

    modport source (output valid, output data_byte, output end_of_record, input ready);
    modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

// Output channel: one result word per input word
interface csvfs_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [4:0] field_index;
    logic [5:0] char_pos;
    logic [7:0] char_byte;
    logic       field_opened;
    logic [5:0] field_size;
    logic       record_done;
    logic [5:0] field_count;

    modport source (
        output valid, output write_valid, output field_index, output char_pos,
        output char_byte, output field_opened, output field_size,
        output record_done, output field_count, input ready
    );
    modport sink (
        input valid, input write_valid, input field_index, input char_pos,
        input char_byte, input field_opened, input field_size,
        input record_done, input field_count, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/csvfs_scan.sv =====
`default_nettype none

// Scanner state and the per-word step logic
module csvfs_scan import csvfs_pkg::*; #(
    parameter int MAX_FIELD_COUNT = DEF_MAX_FIELD_COUNT,
    parameter int FIELD_BYTES     = DEF_FIELD_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_res
);

    localparam int FW = (MAX_FIELD_COUNT > 1) ? $clog2(MAX_FIELD_COUNT) : 1;
    localparam int LW = $clog2(FIELD_BYTES);
    localparam logic [FW-1:0] FIELD_LAST = FW'(MAX_FIELD_COUNT - 1);
    localparam logic [LW-1:0] LEN_LAST   = LW'(FIELD_BYTES - 1);

    t_scan_state   r_state, n_state;
    logic [FW-1:0] r_field, n_field;
    logic [LW-1:0] r_len,   n_len;

    logic          is_quote;
    logic          is_comma;
    logic          keep;
    logic          delim;
    logic          room;
    logic          wr;
    logic [FW:0]   count;

    assign is_quote = (i_item.data_byte == CH_QUOTE);
    assign is_comma = (i_item.data_byte == CH_COMMA);
    assign room     = (r_len < LEN_LAST);
    assign count    = {1'b0, r_field} + {{FW{1'b0}}, 1'b1};

    // Classify the byte against the current state
    always_comb begin
        keep    = 1'b0;
        delim   = 1'b0;
        n_state = r_state;
        case (r_state)
            ST_START: begin
                if (is_quote) begin
                    n_state = ST_QUOTED;
                end else if (is_comma) begin
                    delim = 1'b1;
                end else begin
                    keep    = 1'b1;
                    n_state = ST_PLAIN;
                end
            end
            ST_PLAIN: begin
                if (is_comma) begin
                    delim = 1'b1;
                end else begin
                    keep = 1'b1;
                end
            end
            ST_QUOTED: begin
                if (is_quote) begin
                    n_state = ST_AFTERQ;
                end else begin
                    keep = 1'b1;
                end
            end
            ST_AFTERQ: begin
                // doubled quote keeps one quote; a comma ends the field; anything else falls back to plain
                if (is_quote) begin
                    keep    = 1'b1;
                    n_state = ST_QUOTED;
                end else if (is_comma) begin
                    delim = 1'b1;
                end else begin
                    keep    = 1'b1;
                    n_state = ST_PLAIN;
                end
            end
            default: begin
                n_state = ST_START;
            end
        endcase
        if (delim || i_item.end_of_record) begin
            n_state = ST_START;
        end
    end

    assign wr = keep && room;

    // Counters and result word
    always_comb begin
        n_field = r_field;
        n_len   = r_len;
        o_res   = '0;
        if (i_item.end_of_record) begin
            n_field           = '0;
            n_len             = '0;
            o_res.record_done = 1'b1;
            o_res.field_count = 6'(count);
        end else begin
            if (wr) begin
                n_len             = r_len + LW'(1);
                o_res.write_valid = 1'b1;
                o_res.char_pos    = 6'(r_len);
                o_res.char_byte   = i_item.data_byte;
            end
            if (delim && (r_field < FIELD_LAST)) begin
                n_field            = r_field + FW'(1);
                n_len              = '0;
                o_res.field_opened = 1'b1;
            end
            o_res.field_index = 5'(n_field);
            o_res.field_size  = 6'(n_len);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_field <= '0;
            r_len   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_field <= n_field;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csv_field_splitter_top.sv =====
`default_nettype none

// CSV field splitter. Takes one record byte, or an end-of-record marker, per
// word and returns exactly one result word for each: a write of (field index,
// position, byte) for every kept byte, a flag when a comma opens a new field,
// the running field length, and the field count at the end of a record.
// Quoted fields follow the usual rules: commas inside quotes are literal and a
// doubled quote stores one quote. A field keeps at most FIELD_BYTES-1 bytes;
// later bytes are dropped. From field MAX_FIELD_COUNT-1 on, commas are ignored
// and bytes join the last field. Throughput is one word per cycle while the
// output is not stalled; each word passes the input register, then the scanner
// step, then the result register, which offers its result. Input ready drops
// only when both registers are full and the output is stalled.
module csv_field_splitter_top import csvfs_pkg::*; #(
    parameter int MAX_FIELD_COUNT = DEF_MAX_FIELD_COUNT,
    parameter int FIELD_BYTES     = DEF_FIELD_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csvfs_in_if.sink   i_in,
    csvfs_out_if.source o_out
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    advance;

    // Word moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.data_byte     <= i_in.data_byte;
            r_in.end_of_record <= i_in.end_of_record;
        end
    end

    csvfs_scan #(
        .MAX_FIELD_COUNT (MAX_FIELD_COUNT),
        .FIELD_BYTES     (FIELD_BYTES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.write_valid  = r_out.write_valid;
    assign o_out.field_index  = r_out.field_index;
    assign o_out.char_pos     = r_out.char_pos;
    assign o_out.char_byte    = r_out.char_byte;
    assign o_out.field_opened = r_out.field_opened;
    assign o_out.field_size   = r_out.field_size;
    assign o_out.record_done  = r_out.record_done;
    assign o_out.field_count  = r_out.field_count;

`ifndef NO_ASSERTIONS
    // Input only stalls when the output side is full and held
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled while output free");

    // A write always leaves the length one past its position
    a_write_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.write_valid) |->
        (o_out.field_size == 6'(o_out.char_pos + 6'd1)))
        else $error("field length does not follow write position");

    // A freshly opened field is empty and carries no write
    a_open_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.field_opened) |->
        (o_out.field_size == 6'd0 && !o_out.write_valid))
        else $error("opened field not empty");

    // End of record resets the reported position
    a_done_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.record_done) |->
        (o_out.field_index == 5'd0 && o_out.field_size == 6'd0 && !o_out.write_valid))
        else $error("end of record word carries field data");
`endif

endmodule

`default_nettype wire
